// ----- rtl/sce_pkg.sv -----
package sce_pkg;

	localparam int ETA_FRACTION_BITS = 16;
	localparam int STRIPS_PER_CHIP   = 64;
	localparam int CHIPS_PER_LADDER  = 6;
	localparam int DIV_STEPS         = ETA_FRACTION_BITS + 1;
	localparam int STEP_W            = $clog2(DIV_STEPS);

	localparam logic [1:0] CLS_EDGE   = 2'd0;
	localparam logic [1:0] CLS_CENTRE = 2'd1;
	localparam logic [1:0] CLS_NONE   = 2'd2;

	typedef struct packed {
		logic [15:0] strip_signal;
		logic [8:0]  strip_channel;
		logic        cluster_end;
		logic [8:0]  first_strip;
		logic [8:0]  final_strip;
	} strip_t;

	typedef struct packed {
		logic [16:0] eta_value;
		logic [1:0]  eta_class;
		logic [2:0]  chip_number;
		logic        zero_sum;
	} result_t;

	typedef struct packed {
		logic track;
		logic select;
		logic div_first;
		logic div_step;
		logic load_out;
	} sce_cmd_t;

	typedef struct packed {
		logic end_strip;
		logic out_free;
	} sce_sts_t;

endpackage

// ----- rtl/strip_cluster_eta.sv -----
// Silicon strip cluster eta. Strips of a cluster arrive one per transfer; the
// block tracks the strongest strip and its larger neighbour and, on the strip
// flagged cluster_end, returns one result: eta = signal on the higher channel
// over the sum of the two signals (16 fraction bits, truncated), its region
// class, the readout chip holding the whole cluster (CHIPS_PER_LADDER if no
// single chip holds it), and a zero-sum flag. Strips that do not end a cluster
// do not stall the input. An end strip stalls the input while the block
// selects the operands, runs the restoring divider that yields one quotient
// bit per cycle, and loads the output register. The load, and with it the
// input, waits for as long as the previous result sits stalled in the output
// register. The output register lets the result wait while the next cluster's
// strips stream in.
module strip_cluster_eta import sce_pkg::*; #(
	parameter int MAX_CLUSTER_STRIPS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    strip_valid,
	output logic    strip_stall,
	input  strip_t  strip,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	sce_cmd_t cmd;
	sce_sts_t sts;

	sce_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.strip_valid (strip_valid),
		.strip_stall (strip_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	sce_datapath #(
		.MAX_CLUSTER_STRIPS (MAX_CLUSTER_STRIPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.strip        (strip),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/sce_ctrl.sv -----
module sce_ctrl import sce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     strip_valid,
	output logic     strip_stall,
	input  sce_sts_t sts,
	output sce_cmd_t cmd
);

	typedef enum logic [1:0] {S_TRACK, S_SELECT, S_DIV, S_OUT} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign strip_stall = (state_q != S_TRACK);
	assign accept      = strip_valid && (state_q == S_TRACK);

	always_comb begin
		cmd.track     = accept;
		cmd.select    = (state_q == S_SELECT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.div_first = (state_q == S_DIV) && (step_q == '0);
		cmd.load_out  = (state_q == S_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TRACK;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_TRACK: begin
					if (accept && sts.end_strip) begin
						state_q <= S_SELECT;
					end
				end
				S_SELECT: begin
					state_q <= S_DIV;
					step_q  <= '0;
				end
				S_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_OUT: begin
					if (sts.out_free) begin
						state_q <= S_TRACK;
					end
				end
				default: state_q <= S_TRACK;
			endcase
		end
	end

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		strip_valid && !strip_stall && sts.end_strip |=> strip_stall)
		else $error("end strip transfer did not block input");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SELECT) |=> (state_q == S_DIV) && (step_q == '0))
		else $error("divider did not restart");

	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_OUT) |-> $past(step_q) == STEP_W'(DIV_STEPS - 1))
		else $error("result stage entered before divider finished");

endmodule

// ----- rtl/sce_datapath.sv -----
module sce_datapath import sce_pkg::*; #(
	parameter int MAX_CLUSTER_STRIPS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  strip_t   strip,
	input  sce_cmd_t cmd,
	output sce_sts_t sts,
	output logic     result_valid,
	input  logic     result_stall,
	output result_t  result
);

	localparam int CW = $clog2(MAX_CLUSTER_STRIPS + 1);
	localparam int QW = ETA_FRACTION_BITS + 1;

	logic [CW-1:0] count_q;
	logic          left_v_q, right_v_q;
	logic          out_valid_q;

	logic [15:0] peak_sig_q, left_sig_q, right_sig_q, prev_sig_q;
	logic [8:0]  peak_ch_q, left_ch_q, right_ch_q, prev_ch_q;
	logic [8:0]  first_q, last_q;
	logic [15:0] num_q;
	logic [16:0] sum_q;
	logic [2:0]  chip_q;
	logic [17:0] rem_q;
	logic [QW-1:0] quo_q;

	logic        fresh, take_peak;
	logic        use_left, single;
	logic [15:0] nsig, num_d;
	logic [8:0]  nch;
	logic [16:0] sum_d;
	logic [8:0]  fc, lc, hc;
	logic [2:0]  chip_d;
	logic [17:0] rshift, rdiff;
	logic        ge;
	logic [18:0] n5, s2, s3, s4;
	logic [1:0]  cls;

	assign fresh     = (count_q == '0);
	assign take_peak = fresh || (strip.strip_signal > peak_sig_q);

	assign sts.end_strip = strip.cluster_end;
	assign sts.out_free  = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			left_v_q    <= 1'b0;
			right_v_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.select) begin
				count_q   <= '0;
				left_v_q  <= 1'b0;
				right_v_q <= 1'b0;
			end else if (cmd.track) begin
				if (count_q != CW'(MAX_CLUSTER_STRIPS)) begin
					count_q <= count_q + 1'b1;
				end
				if (take_peak) begin
					left_v_q  <= !fresh;
					right_v_q <= 1'b0;
				end else if (!right_v_q) begin
					right_v_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.track) begin
			prev_sig_q <= strip.strip_signal;
			prev_ch_q  <= strip.strip_channel;
			first_q    <= strip.first_strip;
			last_q     <= strip.final_strip;
			if (take_peak) begin
				peak_sig_q <= strip.strip_signal;
				peak_ch_q  <= strip.strip_channel;
				if (!fresh) begin
					left_sig_q <= prev_sig_q;
					left_ch_q  <= prev_ch_q;
				end
			end else if (!right_v_q) begin
				right_sig_q <= strip.strip_signal;
				right_ch_q  <= strip.strip_channel;
			end
		end
	end

	// pick the neighbour, form numerator and sum, and find the readout chip
	always_comb begin
		use_left = (left_v_q && right_v_q) ? (left_sig_q > right_sig_q) : left_v_q;
		nsig     = use_left ? left_sig_q : right_sig_q;
		nch      = use_left ? left_ch_q : right_ch_q;
		single   = (count_q <= CW'(1));
		if (single) begin
			num_d = 16'd1;
			sum_d = 17'd1;
		end else begin
			num_d = (peak_ch_q > nch) ? peak_sig_q : nsig;
			sum_d = {1'b0, peak_sig_q} + {1'b0, nsig};
		end
		fc = 9'(first_q / STRIPS_PER_CHIP);
		lc = 9'(last_q / STRIPS_PER_CHIP);
		hc = (fc > 9'(CHIPS_PER_LADDER - 1)) ? 9'(CHIPS_PER_LADDER - 1) : fc;
		chip_d = (hc >= lc) ? hc[2:0] : 3'(CHIPS_PER_LADDER);
	end

	// restoring divider, one quotient bit per step
	always_comb begin
		rshift = cmd.div_first ? rem_q : {rem_q[16:0], 1'b0};
		ge     = (rshift >= {1'b0, sum_q});
		rdiff  = rshift - {1'b0, sum_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			num_q  <= num_d;
			sum_q  <= sum_d;
			chip_q <= chip_d;
			rem_q  <= {2'b00, num_d};
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rdiff : rshift;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	// region class on the exact ratio
	always_comb begin
		n5 = {1'b0, num_q, 2'b00} + {3'b000, num_q};
		s2 = {1'b0, sum_q, 1'b0};
		s4 = {sum_q, 2'b00};
		s3 = s2 + {2'b00, sum_q};
		cls = CLS_NONE;
		if (n5 < {2'b00, sum_q} || n5 > s4) begin
			cls = CLS_EDGE;
		end
		if (n5 > s2 && n5 < s3) begin
			cls = CLS_CENTRE;
		end
		if (sum_q == '0) begin
			cls = CLS_EDGE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.eta_value   <= (sum_q == '0) ? 17'd0 : 17'(quo_q);
			result.eta_class   <= cls;
			result.chip_number <= chip_q;
			result.zero_sum    <= (sum_q == '0);
		end
	end

	assign result_valid = out_valid_q;

	a_zero_eta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result.zero_sum |-> result.eta_value == '0 &&
		result.eta_class == CLS_EDGE)
		else $error("zero sum with nonzero eta or wrong class");

	a_eta_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result.eta_value <= 17'(1 << ETA_FRACTION_BITS))
		else $error("eta above one");

	a_num_le_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> {1'b0, num_q} <= sum_q && rem_q <= {1'b0, sum_q})
		else $error("divider operands out of range");

endmodule
